// ===== rtl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Shared widths, register indexes, character codes and the command and
// status types that run between the tab expander controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

    // Fixed field and register widths
    localparam int BYTE_W     = 8;
    localparam int STOP_W     = 16;
    localparam int IV_W       = 6;
    localparam int CNT_REG_W  = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int MAX_STOPS_DEF   = 6;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int MAX_SPACES_DEF  = 64;

    // Register indexes on the configuration port
    localparam int REG_TAB_INTERVAL = 0;
    localparam int REG_STOP_COUNT   = 1;
    localparam int REG_STOP_POS_0   = 2;

    // Reset value of the regular stop spacing
    localparam logic [IV_W-1:0] IV_RESET = 6'd8;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PASS,
        OP_TAB_LOAD,
        OP_SCAN_SKIP,
        OP_SCAN_EQ,
        OP_PICK_STOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIX,
        OP_DIST,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
    } tse_cmd_t;

    typedef struct packed {
        logic is_tab;      // input beat holds a tab
        logic scan_gt;     // current stop lies below the target
        logic scan_eq;     // current stop equals the target
        logic has_stop;    // an explicit stop remains
        logic div_last;    // final remainder step
        logic out_free;    // output register can take a beat
        logic last_space;  // one space left in the run
    } tse_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tab_to_space_expander_core.sv =====
// ----------------------------------------------------------------------------
// tab_to_space_expander_core
// Text stream tab expander: one byte in, the byte or a run of spaces out.
//
// Input stream s_axis carries one text byte per beat; output stream m_axis
// carries one byte per beat, tlast on the final beat caused by an input byte
// and tuser (clipped) on the final space of a cut tab run. Registers go in
// over cfg_we/cfg_addr/cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. A non-tab byte
// appears on m_axis the cycle after it is accepted. A tab is accepted, skips
// the explicit stops below the column and a stop it sits on, picks the stop,
// runs the one-bit serial remainder unit and a fix step when the regular
// spacing applies, sizes the run, then sends one space per cycle while the
// receiver takes them (1 to MAX_SPACES). The next byte is accepted once the
// run has gone out. Reset clears the column, the stop pointer and the output
// valid flag and loads the register reset values. A stalled receiver holds
// the output beat and the block waits; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tab_to_space_expander_core
    import tse_pkg::*;
#(
    parameter int MAX_STOPS   = MAX_STOPS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int MAX_SPACES  = MAX_SPACES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [BYTE_W-1:0]          m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast,   // last_of_run
    output logic                       m_axis_tuser    // [0] clipped
);

    tse_cmd_t  cmd;
    tse_stat_t stat;

    // Controller
    tse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    tse_dp #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS),
        .MAX_SPACES  (MAX_SPACES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

`default_nettype wire

// ===== rtl/tse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tse_ctrl
// Controller of the tab expander: sequences stop scan, remainder steps and
// the emission of the space run, and issues at most one datapath op per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_ctrl
    import tse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire tse_stat_t stat,
    output tse_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_PICK = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_FIX  = 7'b0010000,
        ST_DIST = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and op decode
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = stat.out_free;
                if (stat.out_free && in_valid)
                begin
                    if (stat.is_tab)
                    begin
                        cmd.op     = OP_TAB_LOAD;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.op = OP_PASS;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_gt)
                begin
                    cmd.op = OP_SCAN_SKIP;
                end
                else if (stat.scan_eq)
                begin
                    cmd.op     = OP_SCAN_EQ;
                    state_next = ST_PICK;
                end
                else
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (stat.has_stop)
                begin
                    cmd.op     = OP_PICK_STOP;
                    state_next = ST_DIST;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.op     = OP_DIV_FIX;
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (stat.last_space)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tse_dp.sv =====
// ----------------------------------------------------------------------------
// tse_dp
// Datapath of the tab expander: configuration registers, column and stop
// pointer, target search, serial remainder unit, space counter and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tse_dp
    import tse_pkg::*;
#(
    parameter int MAX_STOPS   = MAX_STOPS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int MAX_SPACES  = MAX_SPACES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tse_cmd_t              cmd,
    output tse_stat_t                  stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [BYTE_W-1:0]     in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BYTE_W-1:0]          out_data,
    output logic                       out_last,
    output logic                       out_user
);

    localparam int IDX_W = $clog2(MAX_STOPS + 1);
    localparam int TGT_W = ((COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W) + 1;
    localparam int DC_W  = $clog2(TGT_W + 1);
    localparam int SP_W  = $clog2(MAX_SPACES + 1);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    // Configuration
    logic [IV_W-1:0]      tab_interval_reg;
    logic [CNT_REG_W-1:0] stop_count_reg;
    logic [STOP_W-1:0]    stop_pos_reg [MAX_STOPS];

    // Committed state
    logic [COLUMN_BITS-1:0] column_reg;
    logic [IDX_W-1:0]       stop_idx_reg;

    // Working registers of a tab
    logic [IDX_W-1:0] work_idx_reg;
    logic [TGT_W-1:0] target_reg;
    logic [TGT_W-1:0] div_sh_reg;
    logic [IV_W-1:0]  rem_reg;
    logic [DC_W-1:0]  div_cnt_reg;
    logic [SP_W-1:0]  space_left_reg;
    logic             clip_pend_reg;

    // Output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_user_reg;

    logic [IDX_W-1:0]       n_eff;
    logic [STOP_W-1:0]      stop_sel;
    logic [TGT_W-1:0]       stop_ext;
    logic [TGT_W-1:0]       col_ext;
    logic                   idx_ok;
    logic [IV_W-1:0]        iv_eff;
    logic [IV_W:0]          rem_sh;
    logic [IV_W:0]          rem_sub;
    logic [IV_W-1:0]        rem_nx;
    logic [TGT_W-1:0]       tgt_gap;
    logic                   dist_clip;
    logic [SP_W-1:0]        space_cnt;
    logic [COLUMN_BITS-1:0] col_sat;
    logic                   out_free;

    // Stop count clamped to the stops held
    assign n_eff = (stop_count_reg > CNT_REG_W'(MAX_STOPS)) ? IDX_W'(MAX_STOPS)
                                                            : IDX_W'(stop_count_reg);

    // Stop under the work pointer
    always_comb
    begin
        stop_sel = '0;
        for (int j = 0; j < MAX_STOPS; j++)
        begin
            if (work_idx_reg == IDX_W'(j))
            begin
                stop_sel = stop_pos_reg[j];
            end
        end
    end

    assign stop_ext = TGT_W'(stop_sel);
    assign col_ext  = TGT_W'(column_reg);
    assign idx_ok   = work_idx_reg < n_eff;

    // One restoring remainder step; zero interval acts as one
    assign iv_eff  = (tab_interval_reg == '0) ? IV_W'(1) : tab_interval_reg;
    assign rem_sh  = {rem_reg, div_sh_reg[TGT_W-1]};
    assign rem_sub = rem_sh - {1'b0, iv_eff};
    assign rem_nx  = (rem_sh >= {1'b0, iv_eff}) ? rem_sub[IV_W-1:0] : rem_sh[IV_W-1:0];

    // Run length and saturated column
    assign tgt_gap   = target_reg - col_ext;
    assign dist_clip = tgt_gap > TGT_W'(MAX_SPACES);
    assign space_cnt = dist_clip ? SP_W'(MAX_SPACES) : tgt_gap[SP_W-1:0];
    assign col_sat   = (target_reg > TGT_W'(COL_MAX)) ? COL_MAX
                                                      : target_reg[COLUMN_BITS-1:0];

    assign out_free = !out_valid_reg || out_ready;

    // Status to the controller
    always_comb
    begin
        stat.is_tab     = in_data == CH_TAB;
        stat.scan_gt    = idx_ok && (target_reg > stop_ext);
        stat.scan_eq    = idx_ok && (target_reg == stop_ext);
        stat.has_stop   = idx_ok;
        stat.div_last   = div_cnt_reg == DC_W'(TGT_W - 1);
        stat.out_free   = out_free;
        stat.last_space = space_left_reg == SP_W'(1);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_interval_reg <= IV_RESET;
            stop_count_reg   <= '0;
            for (int j = 0; j < MAX_STOPS; j++)
            begin
                stop_pos_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_ADDR_W'(REG_TAB_INTERVAL))
            begin
                tab_interval_reg <= cfg_wdata[IV_W-1:0];
            end
            if (cfg_addr == CFG_ADDR_W'(REG_STOP_COUNT))
            begin
                stop_count_reg <= cfg_wdata[CNT_REG_W-1:0];
            end
            for (int j = 0; j < MAX_STOPS; j++)
            begin
                if (cfg_addr == CFG_ADDR_W'(REG_STOP_POS_0 + j))
                begin
                    stop_pos_reg[j] <= cfg_wdata[STOP_W-1:0];
                end
            end
        end
    end

    // Column, stop pointer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            stop_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_PASS)
            begin
                if (in_data == CH_NL)
                begin
                    column_reg   <= '0;
                    stop_idx_reg <= '0;
                end
                else if (in_data == CH_BS)
                begin
                    if (column_reg != '0)
                    begin
                        column_reg <= column_reg - 1'b1;
                    end
                end
                else if (column_reg != COL_MAX)
                begin
                    column_reg <= column_reg + 1'b1;
                end
            end
            else if (cmd.op == OP_DIST)
            begin
                column_reg   <= col_sat;
                stop_idx_reg <= work_idx_reg;
            end

            if (cmd.op == OP_PASS || cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_PASS:
            begin
                out_data_reg <= in_data;
                out_last_reg <= 1'b1;
                out_user_reg <= 1'b0;
            end
            OP_TAB_LOAD:
            begin
                target_reg   <= col_ext;
                work_idx_reg <= stop_idx_reg;
            end
            OP_SCAN_SKIP:
            begin
                work_idx_reg <= work_idx_reg + 1'b1;
            end
            OP_SCAN_EQ:
            begin
                target_reg   <= target_reg + 1'b1;
                work_idx_reg <= work_idx_reg + 1'b1;
            end
            OP_PICK_STOP:
            begin
                if (target_reg < stop_ext)
                begin
                    target_reg <= stop_ext;
                end
                work_idx_reg <= work_idx_reg + 1'b1;
            end
            OP_DIV_INIT:
            begin
                div_sh_reg  <= target_reg;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                div_sh_reg  <= {div_sh_reg[TGT_W-2:0], 1'b0};
                rem_reg     <= rem_nx;
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            OP_DIV_FIX:
            begin
                // next multiple of the interval strictly above the target
                target_reg <= target_reg - TGT_W'(rem_reg) + TGT_W'(iv_eff);
            end
            OP_DIST:
            begin
                space_left_reg <= space_cnt;
                clip_pend_reg  <= dist_clip;
            end
            OP_EMIT:
            begin
                space_left_reg <= space_left_reg - 1'b1;
                out_data_reg   <= CH_SP;
                out_last_reg   <= stat.last_space;
                out_user_reg   <= stat.last_space && clip_pend_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

    // A space run never starts empty
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> space_left_reg != '0)
        else $error("space emitted with empty run counter");

    // Every tab target lies above the column
    a_target_above: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DIST |-> target_reg > col_ext)
        else $error("tab target not above column");

    // The output register is only loaded when it can take a beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PASS || cmd.op == OP_EMIT) |-> out_free)
        else $error("output register overwritten");

    // Committed stop pointer never exceeds MAX_STOPS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DIST |=> stop_idx_reg <= IDX_W'(MAX_STOPS))
        else $error("stop pointer out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tse_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tse_stream_checker
// Passive checker for the tab expander. It mirrors the register writes and
// the column / stop pointer state, expands every accepted input byte into the
// output beats it should cause, and compares each accepted output beat with
// the oldest pending one, field by field.
// ----------------------------------------------------------------------------
module tse_stream_checker
    import tse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,    // [7:0] in_byte
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [BYTE_W-1:0]     m_tdata,    // [7:0] out_byte
    input  wire logic                  m_tlast,    // last_of_run
    input  wire logic                  m_tuser,    // [0] clipped
    output int unsigned                pending_beats,
    output int unsigned                mismatch_count,
    output int unsigned                beats_checked
);

    localparam int unsigned COL_MAX = (1 << COLUMN_BITS_DEF) - 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              clipped;
    } text_beat_t;

    // Beats still owed by the block, oldest first
    text_beat_t expansion_q[$];

    // Shadow registers
    logic [IV_W-1:0]      tab_interval;
    logic [CNT_REG_W-1:0] stop_count;
    logic [STOP_W-1:0]    stop_pos [MAX_STOPS_DEF];

    // Mirrored block state
    int unsigned column;
    int unsigned next_stop;

    int unsigned fails      = 0;
    int unsigned beats_seen = 0;

    task automatic report(input string what, input logic [BYTE_W-1:0] got,
                          input logic [BYTE_W-1:0] want);
        $display("MISMATCH beat %0d: %s got 0x%0h, expected 0x%0h",
                 beats_seen, what, got, want);
        fails++;
    endtask

    // Work out the beats caused by one input byte and update the state
    task automatic expand_byte(input logic [BYTE_W-1:0] b);
        int unsigned active;
        int unsigned idx;
        int unsigned target;
        int unsigned span;
        int unsigned run;
        int unsigned step;
        text_beat_t  beat;
        if (b != CH_TAB) begin
            if (b == CH_NL) begin
                column    = 0;
                next_stop = 0;
            end else if (b == CH_BS) begin
                if (column > 0) column--;
            end else if (column < COL_MAX) begin
                column++;
            end
            beat.data    = b;
            beat.last    = 1'b1;
            beat.clipped = 1'b0;
            expansion_q.push_back(beat);
        end else begin
            active = (stop_count > MAX_STOPS_DEF) ? MAX_STOPS_DEF : stop_count;
            idx    = next_stop;
            target = column;
            // stops behind the column are dropped
            while (idx < active && target > stop_pos[idx]) idx++;
            // sitting on a stop: that stop is used up and the target moves one past it
            if (idx < active && target == stop_pos[idx]) begin
                target++;
                idx++;
            end
            if (idx < active) begin
                if (target < stop_pos[idx]) target = stop_pos[idx];
                idx++;
            end else begin
                // regular stops; a zero spacing behaves as one
                step   = (tab_interval == 0) ? 1 : tab_interval;
                target = (target / step + 1) * step;
            end
            span = target - column;
            run  = (span > MAX_SPACES_DEF) ? MAX_SPACES_DEF : span;
            for (int unsigned k = 1; k <= run; k++) begin
                beat.data    = CH_SP;
                beat.last    = (k == run);
                beat.clipped = (k == run) && (span > MAX_SPACES_DEF);
                expansion_q.push_back(beat);
            end
            column    = (target > COL_MAX) ? COL_MAX : target;
            next_stop = idx & 7;
        end
    endtask

    // Observe register port and both streams at each edge
    always @(posedge clk or negedge rst_n) begin : watch
        text_beat_t want;
        if (!rst_n) begin
            tab_interval = IV_RESET;
            stop_count   = '0;
            for (int s = 0; s < MAX_STOPS_DEF; s++) stop_pos[s] = '0;
            column    = 0;
            next_stop = 0;
            expansion_q.delete();
        end else begin
            // output side first: a beat can never come from this edge's input
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (expansion_q.size() == 0) begin
                    report("unexpected beat, out_byte", m_tdata, '0);
                end else begin
                    want = expansion_q.pop_front();
                    if (m_tdata !== want.data)
                        report("out_byte", m_tdata, want.data);
                    if (m_tlast !== want.last)
                        report("tlast", BYTE_W'(m_tlast), BYTE_W'(want.last));
                    if (m_tuser !== want.clipped)
                        report("tuser", BYTE_W'(m_tuser), BYTE_W'(want.clipped));
                end
            end
            if (s_tvalid && s_tready) expand_byte(s_tdata);
            if (cfg_we) begin
                if (cfg_addr == REG_TAB_INTERVAL)
                    tab_interval = cfg_wdata[IV_W-1:0];
                else if (cfg_addr == REG_STOP_COUNT)
                    stop_count = cfg_wdata[CNT_REG_W-1:0];
                else if (cfg_addr >= REG_STOP_POS_0 &&
                         cfg_addr < REG_STOP_POS_0 + MAX_STOPS_DEF)
                    stop_pos[cfg_addr - REG_STOP_POS_0] = cfg_wdata[STOP_W-1:0];
            end
        end
        pending_beats  <= expansion_q.size();
        mismatch_count <= fails;
        beats_checked  <= beats_seen;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tab expander. A directed pass runs the reset
// setting, explicit stops, stop hits, clipped runs, a zero spacing, an
// oversized stop count, an unordered list and column saturation; random
// settings then carry a mixed text stream with random gaps on both streams
// and one long receiver hold-off. Checking is done by tse_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import tse_pkg::*;

    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 51;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int TIMEOUT_NS      = 10_000_000;

    typedef logic [STOP_W-1:0] stop_list_t [MAX_STOPS_DEF];

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    int unsigned pending_beats;
    int unsigned mismatch_count;
    int unsigned beats_checked;

    // Idling control shared by the two stream processes
    logic quiet         = 1'b1;
    logic pressure_on   = 1'b0;
    logic pressure_done = 1'b0;

    int unsigned bytes_sent       = 0;
    int unsigned tabs_sent        = 0;
    int unsigned settings_applied = 0;

    tab_to_space_expander_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    tse_stream_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tlast        (m_axis_tlast),
        .m_tuser        (m_axis_tuser),
        .pending_beats  (pending_beats),
        .mismatch_count (mismatch_count),
        .beats_checked  (beats_checked)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top NOT OK");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Write every register, one per edge
    task automatic apply_config(input int unsigned iv, input int unsigned cnt,
                                input stop_list_t stops);
        for (int r = 0; r < REG_STOP_POS_0 + MAX_STOPS_DEF; r++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= r[CFG_ADDR_W-1:0];
            if (r == REG_TAB_INTERVAL)
                cfg_wdata <= CFG_DATA_W'(iv);
            else if (r == REG_STOP_COUNT)
                cfg_wdata <= CFG_DATA_W'(cnt);
            else
                cfg_wdata <= stops[r - REG_STOP_POS_0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Offer one byte, optionally after a gap, and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        if (b == CH_TAB) tabs_sent++;
    endtask

    // Stop offering and let every owed beat come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_beats != 0);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: random ready pattern plus one long hold-off on request
    initial begin : receiver
        do @(posedge clk); while (!rst_n);
        forever begin
            if (pressure_on && !pressure_done) begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < PRESSURE_CYCLES; c++) @(posedge clk);
                pressure_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        stop_list_t  stops;
        int unsigned r;
        int unsigned iv;
        int unsigned cnt;
        int unsigned pos;
        logic [BYTE_W-1:0] b;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: spacing 8, no explicit stops
        send_byte(CH_BS);              // backspace at column zero
        send_byte(8'h61);
        send_byte(CH_TAB);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_BS);
        send_byte(CH_NL);
        send_byte(CH_TAB);

        // Explicit stops, a hit on a stop, a clipped run, then regular stops
        wait_drained();
        stops = '{16'd4, 16'd10, 16'd200, 16'd0, 16'd0, 16'd0};
        apply_config(63, 3, stops);
        send_byte(CH_NL);
        repeat (4) send_byte(8'h61);
        send_byte(CH_TAB);             // on stop 4, runs on to 10
        send_byte(CH_TAB);             // to 200, cut at 64 spaces
        send_byte(CH_TAB);             // list used up, next multiple of 63

        // Zero spacing, oversized count, unordered list, column saturation
        wait_drained();
        stops = '{16'd100, 16'd5, 16'd65532, 16'd3, 16'd0, 16'd65535};
        apply_config(0, 7, stops);
        send_byte(CH_NL);
        send_byte(CH_TAB);
        send_byte(CH_TAB);             // skips 5, jumps to 65532
        repeat (4) send_byte(8'h7A);   // the third reaches the column ceiling, the last is held there
        send_byte(CH_TAB);             // on the final stop, regular rule follows
        send_byte(CH_TAB);
        send_byte(CH_BS);

        // Random settings with a mixed text stream
        quiet = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            r   = $urandom_range(0, 9);
            iv  = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 63 : $urandom_range(2, 12);
            cnt = $urandom_range(0, 7);
            if ($urandom_range(0, 5) == 0) begin
                // anywhere, in no particular order
                for (int s = 0; s < MAX_STOPS_DEF; s++) stops[s] = STOP_W'($urandom);
            end else begin
                pos = $urandom_range(0, 6);
                for (int s = 0; s < MAX_STOPS_DEF; s++) begin
                    stops[s] = pos[STOP_W-1:0];
                    pos += $urandom_range(0, 14);
                end
            end
            apply_config(iv, cnt, stops);
            if (p == 1) pressure_on = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 18)      b = CH_TAB;
                else if (r < 24) b = CH_BS;
                else if (r < 32) b = CH_NL;
                else if (r < 44) b = BYTE_W'($urandom_range(0, 255));
                else             b = BYTE_W'($urandom_range(33, 126));
                send_byte(b);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input bytes (%0d tabs) under %0d register settings.",
                 bytes_sent, tabs_sent, settings_applied);
        $display("Compared %0d output beats, %0d mismatches.", beats_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
